// ===== hw/rtl/local_max_3x3_detector_macros.svh =====
// ----------------------------------------------------------------------------
// local_max_3x3_detector assertion macros
// Shared concurrent check forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAX_3X3_DETECTOR_MACROS_SVH
`define LOCAL_MAX_3X3_DETECTOR_MACROS_SVH

// property checked at every clock edge outside reset
`define LMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// effect checked in the cycle after its cause
`define LMD_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ===== hw/rtl/lmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared widths, register indexes and transaction types of the detector.
// ----------------------------------------------------------------------------
package lmd_pkg;

    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int PIX_W     = 16;
    localparam int COUNT_W   = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [DIM_W-1:0]     ROW_LIMIT = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    localparam int OPQ_DEPTH = 4;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // one operation handed from the front to the back
    typedef struct packed {
        logic             wr_en;
        logic [1:0]       wr_bank;
        logic [POS_W-1:0] wr_col;
        logic             dec_en;
        logic [POS_W-1:0] dec_row;
        logic [POS_W-1:0] dec_col;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             last;
    } t_op;

    typedef struct packed {
        logic               is_max;
        logic [PIX_W-1:0]   value;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [COUNT_W-1:0] count;
        logic               done;
    } t_result;

endpackage

// ===== hw/rtl/local_max_3x3_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_max_3x3_detector
// 3x3 local-maximum detector over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Configure frame_rows (index 0) and frame_cols (index 1) through the write
//   port while the block is idle; each write restarts the frame. Push one
//   item per transaction: kind 0 carries a sample in raster order, kind 1 is
//   a drain step. Once a frame's samples are all in, every item (of either
//   kind) flushes one pending decision until the final position is out.
//   Each decided position gives one result, popped from the result queue;
//   the final position of a frame carries frame_done.
// Timing:
//   Throughput is one item per cycle unless stalled, set by the single write
//   and dual read pass per item through the four banked row stores. The
//   result for position p is registered after the item that completes its
//   window (sample p + frame_cols + 1, or the drain item after frame end).
// Reset and stalls:
//   Reset sets both dimensions to 1 and clears all position counters and
//   queues; the row stores are not cleared, as no entry is used before this
//   frame writes it. When pop stays low the 4-entry result queue fills, the
//   back stops issuing, the 4-entry operation queue fills and full rises.
// ----------------------------------------------------------------------------
module local_max_3x3_detector #(
    parameter int MAX_COLS    = 1024,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lmd_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_kind,
    input  logic signed [15:0]             i_pixel_value,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_is_max,
    output logic signed [15:0]             o_max_value,
    output logic [9:0]                     o_out_row,
    output logic [9:0]                     o_out_col,
    output logic [19:0]                    o_max_count,
    output logic                           o_frame_done
);

    localparam int COL_LIM = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int OPQ_W   = $bits(lmd_pkg::t_op) + VALUE_WIDTH;

    logic                          accept;
    logic [VALUE_WIDTH-1:0]        pix_data;
    logic                          front_push, front_clear;
    lmd_pkg::t_op                  front_op;
    logic [OPQ_W-1:0]              opq_out;
    lmd_pkg::t_op                  q_op;
    logic [VALUE_WIDTH-1:0]        q_data;
    logic                          opq_empty, back_pop;
    logic                          res_push;
    lmd_pkg::t_result              res_in, res_head;
    logic [lmd_pkg::RES_CNT_W-1:0] res_count;

    assign accept   = push && !full;
    assign pix_data = VALUE_WIDTH'($unsigned(i_pixel_value));

    lmd_front #(
        .COL_LIM (COL_LIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_kind     (i_kind),
        .o_op_push  (front_push),
        .o_op       (front_op),
        .o_clear    (front_clear)
    );

    lmd_fifo #(
        .WIDTH (OPQ_W),
        .DEPTH (lmd_pkg::OPQ_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_op, pix_data}),
        .i_pop   (back_pop),
        .o_data  (opq_out),
        .o_empty (opq_empty),
        .o_full  (full),
        .o_count ()
    );

    assign {q_op, q_data} = opq_out;

    lmd_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COL_LIM     (COL_LIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (front_clear),
        .i_op_valid  (!opq_empty),
        .i_op        (q_op),
        .i_op_data   (q_data),
        .o_op_pop    (back_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    lmd_fifo #(
        .WIDTH ($bits(lmd_pkg::t_result)),
        .DEPTH (lmd_pkg::RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty),
        .o_full  (),
        .o_count (res_count)
    );

    assign o_is_max     = res_head.is_max;
    assign o_max_value  = res_head.value;
    assign o_out_row    = res_head.row;
    assign o_out_col    = res_head.col;
    assign o_max_count  = res_head.count;
    assign o_frame_done = res_head.done;

endmodule

// ===== hw/rtl/lmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_fifo
// Small register queue with occupancy count, first word shown at the head.
// ----------------------------------------------------------------------------
module lmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/lmd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_front
// Frame geometry, input and decision position tracking; turns each accepted
// item into a store write, a window decision, both or nothing.
// ----------------------------------------------------------------------------
`include "local_max_3x3_detector_macros.svh"

module lmd_front #(
    parameter int COL_LIM = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lmd_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_kind,
    output logic                           o_op_push,
    output lmd_pkg::t_op                   o_op,
    output logic                           o_clear
);

    localparam int PW = lmd_pkg::POS_W;
    localparam int DW = lmd_pkg::DIM_W;
    localparam logic [DW-1:0] COLS_HI = DW'(COL_LIM);

    logic [DW-1:0] r_rows, n_rows;
    logic [DW-1:0] r_cols, n_cols;
    logic [PW-1:0] r_in_row, n_in_row;
    logic [PW-1:0] r_in_col, n_in_col;
    logic          r_in_done, n_in_done;
    logic [DW-1:0] r_lag, n_lag;
    logic [PW-1:0] r_dec_row, n_dec_row;
    logic [PW-1:0] r_dec_col, n_dec_col;

    logic [PW-1:0] rows_m1, cols_m1;
    logic          is_pixel, dec_now, dec_right, dec_bottom;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                                input logic [DW-1:0] hi);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign o_clear = i_cfg_we;

    always_comb begin
        rows_m1    = PW'(r_rows - 1'b1);
        cols_m1    = PW'(r_cols - 1'b1);
        is_pixel   = !r_in_done && !i_kind;
        // decide once the sample right-below the pending position is in
        dec_now    = r_in_done || (is_pixel && (r_lag >= r_cols + 1'b1));
        dec_right  = (r_dec_col == cols_m1);
        dec_bottom = (r_dec_row == rows_m1);

        o_op.wr_en    = is_pixel;
        o_op.wr_bank  = r_in_row[1:0];
        o_op.wr_col   = r_in_col;
        o_op.dec_en   = dec_now;
        o_op.dec_row  = r_dec_row;
        o_op.dec_col  = r_dec_col;
        o_op.top_ok   = (r_dec_row != '0);
        o_op.bot_ok   = !dec_bottom;
        o_op.left_ok  = (r_dec_col != '0);
        o_op.right_ok = !dec_right;
        o_op.last     = dec_right && dec_bottom;
        o_op_push     = i_accept && (is_pixel || dec_now);

        n_rows    = r_rows;
        n_cols    = r_cols;
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_in_done = r_in_done;
        n_lag     = r_lag;
        n_dec_row = r_dec_row;
        n_dec_col = r_dec_col;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                lmd_pkg::REG_FRAME_ROWS: n_rows = clamp_dim(i_cfg_data, lmd_pkg::ROW_LIMIT);
                lmd_pkg::REG_FRAME_COLS: n_cols = clamp_dim(i_cfg_data, COLS_HI);
                default: ;
            endcase
            n_in_row  = '0;
            n_in_col  = '0;
            n_in_done = 1'b0;
            n_lag     = '0;
            n_dec_row = '0;
            n_dec_col = '0;
        end else if (i_accept) begin
            if (is_pixel) begin
                if (r_in_col == cols_m1) begin
                    n_in_col = '0;
                    if (r_in_row == rows_m1) begin
                        n_in_row  = '0;
                        n_in_done = 1'b1;
                    end else begin
                        n_in_row = r_in_row + 1'b1;
                    end
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
                if (!dec_now) begin
                    n_lag = r_lag + 1'b1;
                end
            end
            if (dec_now) begin
                if (dec_right) begin
                    n_dec_col = '0;
                    n_dec_row = r_dec_row + 1'b1;
                end else begin
                    n_dec_col = r_dec_col + 1'b1;
                end
                // final position of the frame: start the next one
                if (dec_right && dec_bottom) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_in_done = 1'b0;
                    n_lag     = '0;
                    n_dec_row = '0;
                    n_dec_col = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= DW'(1);
            r_cols    <= DW'(1);
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_done <= 1'b0;
            r_lag     <= '0;
            r_dec_row <= '0;
            r_dec_col <= '0;
        end else begin
            r_rows    <= n_rows;
            r_cols    <= n_cols;
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_in_done <= n_in_done;
            r_lag     <= n_lag;
            r_dec_row <= n_dec_row;
            r_dec_col <= n_dec_col;
        end
    end

    `LMD_ASSERT(a_lag_bound, !r_in_done |-> (r_lag <= r_cols + 1'b1), "input lead over decisions too large")
    `LMD_ASSERT(a_last_after_input, (o_op_push && o_op.dec_en && o_op.last) |-> r_in_done, "frame closed before all input")
    `LMD_ASSERT(a_dec_in_frame, (o_op_push && o_op.dec_en) |-> ((DW'(o_op.dec_row) < r_rows) && (DW'(o_op.dec_col) < r_cols)), "decision outside frame")

endmodule

// ===== hw/rtl/lmd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_back
// Four banked row stores, 3x3 window compare and maxima counting; issues
// one operation per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`include "local_max_3x3_detector_macros.svh"

module lmd_back #(
    parameter int VALUE_WIDTH = 16,
    parameter int COL_LIM     = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_op_valid,
    input  lmd_pkg::t_op                   i_op,
    input  logic [VALUE_WIDTH-1:0]         i_op_data,
    output logic                           o_op_pop,
    input  logic [lmd_pkg::RES_CNT_W-1:0]  i_res_count,
    output logic                           o_res_push,
    output lmd_pkg::t_result               o_res
);

    localparam int VW  = VALUE_WIDTH;
    localparam int CW  = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
    localparam int PW  = lmd_pkg::POS_W;
    localparam int QW  = lmd_pkg::RES_CNT_W + 1;

    logic [QW-1:0]  pending;
    logic [PW-1:0]  col_p1, rd_b_col;
    logic [CW-1:0]  rd_a_addr, rd_b_addr;

    logic [VW-1:0]  r_rd_a [4];
    logic [VW-1:0]  r_rd_b [4];

    logic           r_b1_dec;
    lmd_pkg::t_op   r_b1_op;
    logic [VW-1:0]  r_left [3];
    logic [VW-1:0]  col_a [3];
    logic [VW-1:0]  col_b [3];
    logic [2:0]     row_ok;
    logic           any_gt;

    logic           r_b2_valid;
    logic           r_b2_is_max;
    logic [VW-1:0]  r_b2_value;
    logic [PW-1:0]  r_b2_row, r_b2_col;
    logic           r_b2_last;
    logic [lmd_pkg::COUNT_W-1:0] r_cnt, cnt_next;

    function automatic logic gt(input logic [VW-1:0] a, input logic [VW-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

    // credit: results in flight plus those queued must fit the result queue
    assign pending  = QW'(i_res_count) + QW'(r_b1_dec) + QW'(r_b2_valid);
    assign o_op_pop = i_op_valid && (pending < QW'(lmd_pkg::RES_DEPTH));

    assign col_p1    = i_op.dec_col + 1'b1;
    assign rd_b_col  = i_op.right_ok ? col_p1 : i_op.dec_col;
    assign rd_a_addr = i_op.dec_col[CW-1:0];
    assign rd_b_addr = rd_b_col[CW-1:0];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [VW-1:0] r_mem [COL_LIM];
        logic          wr_hit, fwd_a, fwd_b;

        assign wr_hit = o_op_pop && i_op.wr_en && (i_op.wr_bank == 2'(b));
        // the sample written by this operation may be one it reads
        assign fwd_a  = wr_hit && (i_op.wr_col == i_op.dec_col);
        assign fwd_b  = wr_hit && (i_op.wr_col == rd_b_col);

        always_ff @(posedge i_clk) begin
            if (wr_hit) begin
                r_mem[i_op.wr_col[CW-1:0]] <= i_op_data;
            end
            if (o_op_pop) begin
                r_rd_a[b] <= fwd_a ? i_op_data : r_mem[rd_a_addr];
                r_rd_b[b] <= fwd_b ? i_op_data : r_mem[rd_b_addr];
            end
        end
    end

    // rows r-1, r, r+1 live in banks (r-1)&3, r&3, (r+1)&3
    always_comb begin
        case (r_b1_op.dec_row[1:0])
            2'd0: begin
                col_a[0] = r_rd_a[3]; col_a[1] = r_rd_a[0]; col_a[2] = r_rd_a[1];
                col_b[0] = r_rd_b[3]; col_b[1] = r_rd_b[0]; col_b[2] = r_rd_b[1];
            end
            2'd1: begin
                col_a[0] = r_rd_a[0]; col_a[1] = r_rd_a[1]; col_a[2] = r_rd_a[2];
                col_b[0] = r_rd_b[0]; col_b[1] = r_rd_b[1]; col_b[2] = r_rd_b[2];
            end
            2'd2: begin
                col_a[0] = r_rd_a[1]; col_a[1] = r_rd_a[2]; col_a[2] = r_rd_a[3];
                col_b[0] = r_rd_b[1]; col_b[1] = r_rd_b[2]; col_b[2] = r_rd_b[3];
            end
            default: begin
                col_a[0] = r_rd_a[2]; col_a[1] = r_rd_a[3]; col_a[2] = r_rd_a[0];
                col_b[0] = r_rd_b[2]; col_b[1] = r_rd_b[3]; col_b[2] = r_rd_b[0];
            end
        endcase
    end

    always_comb begin
        row_ok = {r_b1_op.bot_ok, 1'b1, r_b1_op.top_ok};
        any_gt = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (row_ok[k]) begin
                if (k != 1 && gt(col_a[k], col_a[1])) begin
                    any_gt = 1'b1;
                end
                if (r_b1_op.left_ok && gt(r_left[k], col_a[1])) begin
                    any_gt = 1'b1;
                end
                if (r_b1_op.right_ok && gt(col_b[k], col_a[1])) begin
                    any_gt = 1'b1;
                end
            end
        end
    end

    always_comb begin
        cnt_next = r_cnt;
        if (r_b2_is_max && (r_cnt != lmd_pkg::COUNT_MAX)) begin
            cnt_next = r_cnt + 1'b1;
        end
        o_res_push   = r_b2_valid;
        o_res.is_max = r_b2_is_max;
        o_res.value  = lmd_pkg::PIX_W'(r_b2_value);
        o_res.row    = r_b2_row;
        o_res.col    = r_b2_col;
        o_res.count  = cnt_next;
        o_res.done   = r_b2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_dec   <= 1'b0;
            r_b2_valid <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_b1_dec   <= o_op_pop && i_op.dec_en;
            r_b2_valid <= r_b1_dec;
            if (i_clear) begin
                r_cnt <= '0;
            end else if (r_b2_valid) begin
                r_cnt <= r_b2_last ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_b1_op <= i_op;
        end
        if (r_b1_dec) begin
            // centre column becomes the left column of the next position
            for (int k = 0; k < 3; k++) begin
                r_left[k] <= col_a[k];
            end
            r_b2_is_max <= !any_gt;
            r_b2_value  <= col_a[1];
            r_b2_row    <= r_b1_op.dec_row;
            r_b2_col    <= r_b1_op.dec_col;
            r_b2_last   <= r_b1_op.last;
        end
    end

    `LMD_ASSERT(a_res_room, r_b2_valid |-> (i_res_count < lmd_pkg::RES_CNT_W'(lmd_pkg::RES_DEPTH)), "result queue overrun")
    `LMD_ASSERT_NEXT(a_count_restart, r_b2_valid && r_b2_last, r_cnt == '0, "maxima count kept past frame end")
    `LMD_ASSERT_NEXT(a_dec_reaches_out, r_b1_dec, r_b2_valid, "decision lost between stages")

endmodule
